[sv/sti_pkg.sv]
package sti_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int FILL_W   = 9;
    localparam int SLOT_W   = 8;

    localparam logic [FUNC_W-1:0] FN_INSERT      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SEARCH      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_READ        = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE_AT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE_LAST = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BS_RD,
        S_BS_CMP,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_RD,
        S_RD_DONE,
        S_OUT
    } t_state;

endpackage

[sv/sorted_table_insert_search_top.sv]
// Sorted key table: keeps up to DEPTH signed keys in ascending order in one
// single-port-read, single-port-write synchronous memory.
// Input channel (i_valid/o_ready) carries func, key and slot; output channel
// (o_valid/i_ready) carries status, position, entry_value and fill_after.
// Exactly one result per input item. One item is worked on at a time.
// Read and remove-last read the entry (S_RD, S_RD_DONE); search runs a
// binary search (S_BS_RD, S_BS_CMP), then reads the entry it found; insert
// runs the same search, then shifts entries up via S_SH_RD and S_SH_WR;
// remove-at shifts them down in S_SH_WR. Errors go straight to S_OUT.
// The result waits in an output register while the receiver stalls; the
// next item is taken only once it has been transferred.
// Reset clears the fill count to zero; the memory keeps no reset value and
// needs no clearing, since only entries below the count are ever read.
module sorted_table_insert_search_top #(
    parameter int DEPTH = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sti_pkg::FUNC_W-1:0]    i_func,
    input  logic signed [31:0]            i_key,
    input  logic [sti_pkg::SLOT_W-1:0]    i_slot,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sti_pkg::STATUS_W-1:0]  o_status,
    output logic [sti_pkg::POS_W-1:0]     o_position,
    output logic signed [31:0]            o_entry_value,
    output logic [sti_pkg::FILL_W-1:0]    o_fill_after
);
    import sti_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    t_state r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [KEY_WIDTH-1:0] r_key, n_key, key_ext;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_idx, n_idx;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0] r_val, n_val;
    logic [FILL_W-1:0] r_fo, n_fo;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [KEY_WIDTH-1:0] wdata, rdata;
    logic [CW-1:0] mid;
    logic slot_in;
    logic less;

    sti_mem #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_comb begin
        if (KEY_WIDTH <= 32) begin
            key_ext = KEY_WIDTH'(i_key);
        end else begin
            key_ext = KEY_WIDTH'($signed(i_key));
        end
    end

    function automatic logic [31:0] to32(input logic [KEY_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign less     = $signed(rdata) < $signed(r_key);
    // The slot is compared at full width so that a small table never aliases it.
    assign slot_in  = (32'(i_slot) < 32'(r_fill));
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_position = r_pos;
    assign o_entry_value = r_val;
    assign o_fill_after = r_fo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
        r_func <= n_func; r_key <= n_key; r_lo <= n_lo; r_hi <= n_hi;
        r_idx <= n_idx; r_status <= n_status;
        r_pos <= n_pos; r_val <= n_val; r_fo <= n_fo;
    end

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_func = r_func; n_key = r_key;
        n_lo = r_lo; n_hi = r_hi; n_idx = r_idx;
        n_status = r_status; n_pos = r_pos; n_val = r_val; n_fo = r_fo;
        we = 1'b0; waddr = r_idx[AW-1:0]; wdata = r_key;
        raddr = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func; n_key = key_ext;
                    n_status = ST_OK; n_pos = '0; n_val = '0;
                    n_fo = FILL_W'(r_fill); n_lo = '0; n_hi = r_fill;
                    n_state = S_OUT;
                    case (i_func)
                        FN_INSERT: begin
                            if (r_fill == CW'(DEPTH)) n_status = ST_FULL;
                            else n_state = S_BS_RD;
                        end
                        FN_SEARCH: begin
                            if (r_fill == '0) n_status = ST_EMPTY;
                            else n_state = S_BS_RD;
                        end
                        FN_READ, FN_REMOVE_AT: begin
                            if (r_fill == '0) n_status = ST_EMPTY;
                            else if (!slot_in) n_status = ST_RANGE;
                            else begin
                                n_idx = CW'(i_slot);
                                n_state = S_RD;
                            end
                        end
                        FN_REMOVE_LAST: begin
                            if (r_fill == '0) n_status = ST_EMPTY;
                            else begin
                                n_idx = r_fill - 1'b1;
                                n_state = S_RD;
                            end
                        end
                        default: n_status = ST_RANGE;
                    endcase
                end
            end
            S_BS_RD: begin
                if (r_lo < r_hi) begin
                    raddr = mid[AW-1:0];
                    n_idx = mid;
                    n_state = S_BS_CMP;
                end else if (r_func == FN_INSERT) begin
                    // Lower bound found: shift entries [lo, fill) up by one.
                    n_pos = POS_W'(r_lo);
                    n_val = to32(r_key);
                    n_idx = r_fill;
                    n_state = (r_fill == r_lo) ? S_PUT : S_SH_RD;
                end else begin
                    n_idx = r_lo;
                    n_state = (r_lo < r_fill) ? S_RD : S_OUT;
                    if (r_lo >= r_fill) n_status = ST_MISS;
                end
            end
            S_BS_CMP: begin
                if (less) n_lo = r_idx + 1'b1;
                else n_hi = r_idx;
                n_state = S_BS_RD;
            end
            S_SH_RD: begin
                // Read the entry below the current hole.
                raddr = AW'(r_idx - 1'b1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                if (r_func == FN_INSERT) begin
                    we = 1'b1; waddr = r_idx[AW-1:0]; wdata = rdata;
                    n_idx = r_idx - 1'b1;
                    n_state = ((r_idx - 1'b1) == r_lo) ? S_PUT : S_SH_RD;
                end else begin
                    we = 1'b1; waddr = AW'(r_idx - 1'b1); wdata = rdata;
                    if (r_idx + 1'b1 < r_fill) begin
                        n_idx = r_idx + 1'b1;
                        raddr = AW'(r_idx + 1'b1);
                    end else begin
                        n_fill = r_fill - 1'b1;
                        n_fo = FILL_W'(r_fill - 1'b1);
                        n_state = S_OUT;
                    end
                end
            end
            S_PUT: begin
                we = 1'b1; waddr = r_idx[AW-1:0]; wdata = r_key;
                n_fill = r_fill + 1'b1;
                n_fo = FILL_W'(r_fill + 1'b1);
                n_state = S_OUT;
            end
            S_RD: begin
                raddr = r_idx[AW-1:0];
                n_state = S_RD_DONE;
            end
            S_RD_DONE: begin
                n_state = S_OUT;
                n_pos = POS_W'(r_idx);
                n_val = to32(rdata);
                case (r_func)
                    FN_SEARCH: begin
                        if (rdata != r_key) begin
                            n_status = ST_MISS; n_pos = '0; n_val = '0;
                        end
                    end
                    FN_REMOVE_AT: begin
                        if (r_idx + 1'b1 < r_fill) begin
                            // Shift down: read idx+1, write it at idx.
                            n_idx = r_idx + 1'b1;
                            raddr = AW'(r_idx + 1'b1);
                            n_state = S_SH_WR;
                        end else begin
                            n_fill = r_fill - 1'b1;
                            n_fo = FILL_W'(r_fill - 1'b1);
                        end
                    end
                    FN_REMOVE_LAST: begin
                        n_fill = r_fill - 1'b1;
                        n_fo = FILL_W'(r_fill - 1'b1);
                    end
                    default: ;
                endcase
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[sv/sti_mem.sv]
module sti_mem #(
    parameter int DEPTH = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [KEY_WIDTH-1:0]     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [KEY_WIDTH-1:0]     o_rdata
);
    logic [KEY_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/sti_checker.sv]
module sti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [7:0]  o_position,
    input logic [31:0] o_entry_value,
    input logic [8:0]  o_fill_after
);
    import sti_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_fill_after))
        else $error("result changed while stalled");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while result pending");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_position == '0 && o_entry_value == '0)
        else $error("failed result carries data");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready after transfer");
endmodule

bind sorted_table_insert_search_top sti_checker u_sti_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import sti_pkg::*;

    localparam int DEPTH = 256;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [31:0]         entry_value;
        logic [FILL_W-1:0]   fill_after;
    } t_result;

    // Tracks the expected key table and queues one result per accepted request.
    class table_scoreboard;
        logic [31:0]      keys[DEPTH];
        int unsigned      count;
        t_result          pending[$];
        int unsigned      errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function int unsigned first_not_less(logic [31:0] k);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if ($signed(keys[mid]) < $signed(k)) lo = mid + 1;
                else hi = mid;
            end
            return lo;
        endfunction

        function void note_request(logic [FUNC_W-1:0] fn, logic [31:0] k, logic [7:0] s);
            t_result r;
            int unsigned p;
            r = '0;
            case (fn)
                FN_INSERT: begin
                    if (count >= DEPTH) r.status = ST_FULL;
                    else begin
                        p = first_not_less(k);
                        for (int i = count; i > p; i--) keys[i] = keys[i-1];
                        keys[p] = k;
                        count++;
                        r.status = ST_OK; r.position = POS_W'(p); r.entry_value = k;
                    end
                end
                FN_SEARCH: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else begin
                        p = first_not_less(k);
                        if (p < count && keys[p] == k) begin
                            r.status = ST_OK; r.position = POS_W'(p); r.entry_value = k;
                        end else r.status = ST_MISS;
                    end
                end
                FN_READ: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if (s >= count) r.status = ST_RANGE;
                    else begin
                        r.status = ST_OK; r.position = s; r.entry_value = keys[s];
                    end
                end
                FN_REMOVE_AT: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if (s >= count) r.status = ST_RANGE;
                    else begin
                        r.status = ST_OK; r.position = s; r.entry_value = keys[s];
                        for (int i = s; i + 1 < count; i++) keys[i] = keys[i+1];
                        count--;
                    end
                end
                FN_REMOVE_LAST: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else begin
                        count--;
                        r.status = ST_OK; r.position = POS_W'(count);
                        r.entry_value = keys[count];
                    end
                end
                default: r.status = ST_RANGE;
            endcase
            r.fill_after = FILL_W'(count);
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result w;
            if (pending.size() == 0) begin
                $error("unexpected result transfer: status %0d", got.status);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status) begin
                $error("status: expected %0d, got %0d", w.status, got.status); errors++;
            end
            if (got.position !== w.position) begin
                $error("position: expected %0d, got %0d", w.position, got.position); errors++;
            end
            if (got.entry_value !== w.entry_value) begin
                $error("entry_value: expected %h, got %h", w.entry_value, got.entry_value);
                errors++;
            end
            if (got.fill_after !== w.fill_after) begin
                $error("fill_after: expected %0d, got %0d", w.fill_after, got.fill_after);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [FUNC_W-1:0]  i_func;
    logic signed [31:0] i_key;
    logic [SLOT_W-1:0]  i_slot;
    logic               o_valid;
    logic               i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [POS_W-1:0]   o_position;
    logic signed [31:0] o_entry_value;
    logic [FILL_W-1:0]  o_fill_after;

    table_scoreboard sb;
    bit  hold_output;
    logic [31:0] key_pool[$];

    sorted_table_insert_search_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Keeps the valid high across back-to-back transfers.
    task automatic send_request(logic [FUNC_W-1:0] fn, logic [31:0] k, logic [7:0] s,
                                bit allow_gap);
        int unsigned gap;
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= fn;
        i_key   <= k;
        i_slot  <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(fn, k, s);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom_range(0, 15) - 8;
        if (r == 2) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} - $urandom_range(0, 1);
        if (r < 5 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    task automatic random_request(int unsigned bias);
        int unsigned r;
        logic [31:0] k;
        logic [7:0]  s;
        r = $urandom_range(0, 99);
        k = random_key();
        s = (sb.count > 0 && $urandom_range(0, 3) != 0) ?
            8'($urandom_range(0, sb.count - 1)) : 8'($urandom());
        if (r < bias) begin
            key_pool.push_back(k);
            if (key_pool.size() > 64) void'(key_pool.pop_front());
            send_request(FN_INSERT, k, s, 1);
        end else if (r < bias + 15) send_request(FN_SEARCH, k, s, 1);
        else if (r < bias + 27) send_request(FN_READ, k, s, 1);
        else if (r < bias + 38) send_request(FN_REMOVE_AT, k, s, 1);
        else if (r < 98) send_request(FN_REMOVE_LAST, k, s, 1);
        else send_request(FUNC_W'($urandom_range(5, 7)), k, s, 1);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int unsigned gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_output) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_output = 1'b0;
            end
            gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid && i_ready)
                sb.check_result('{o_status, o_position, o_entry_value, o_fill_after});
        end
    end

    initial begin
        int unsigned waited;
        sb = new();
        hold_output = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_func  <= FN_INSERT;
        i_key   <= '0;
        i_slot  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table errors, extremes, duplicates, bad codes.
        send_request(FN_SEARCH, 32'h0, 8'd0, 0);
        send_request(FN_READ, 32'h0, 8'd0, 0);
        send_request(FN_REMOVE_AT, 32'h0, 8'd0, 0);
        send_request(FN_REMOVE_LAST, 32'h0, 8'd0, 0);
        send_request(FN_INSERT, 32'h0001_0000, 8'd0, 0);
        send_request(FN_INSERT, 32'h7FFF_FFFF, 8'd0, 0);
        send_request(FN_INSERT, 32'h8000_0000, 8'd0, 0);
        send_request(FN_INSERT, 32'hFFFF_FFFF, 8'd0, 0);
        send_request(FN_INSERT, 32'h0001_0000, 8'd0, 0);
        send_request(FN_SEARCH, 32'h0001_0000, 8'd0, 0);
        send_request(FN_SEARCH, 32'h8000_0000, 8'd0, 0);
        send_request(FN_SEARCH, 32'h7FFF_FFFF, 8'd0, 0);
        send_request(FN_SEARCH, 32'h0000_0005, 8'd0, 0);
        send_request(FN_READ, 32'h0, 8'd4, 0);
        send_request(FN_READ, 32'h0, 8'd5, 0);
        send_request(FN_READ, 32'h0, 8'd255, 0);
        send_request(FN_REMOVE_AT, 32'h0, 8'd1, 0);
        send_request(FN_REMOVE_AT, 32'h0, 8'd9, 0);
        send_request(3'd5, 32'hFFFF_FFFF, 8'hFF, 0);
        send_request(3'd6, 32'h0, 8'h0, 0);
        send_request(3'd7, 32'h0, 8'h0, 0);
        send_request(FN_REMOVE_LAST, 32'h0, 8'd0, 0);
        wait_drained();

        // Back-pressure: the block stalls its input while the output is held.
        hold_output = 1'b1;
        for (int i = 0; i < 12; i++) random_request(60);
        wait_drained();

        // Fill the table to the top, then probe full behavior and drain it.
        while (sb.count < DEPTH) random_request(92);
        for (int i = 0; i < 6; i++) send_request(FN_INSERT, random_key(), 8'd0, 1);
        send_request(FN_READ, 32'h0, 8'd255, 0);
        send_request(FN_REMOVE_AT, 32'h0, 8'd255, 0);
        send_request(FN_INSERT, 32'h0, 8'd0, 0);
        while (sb.count > 0) random_request(5);
        wait_drained();

        for (int i = 0; i < 1300; i++) random_request((i / 150) % 2 == 0 ? 45 : 30);

        wait_drained();
        waited = 0;
        while (waited < 600) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
